FILE: sv/fca_pkg.sv
// Package for the Forth cell ALU: cell widths, opcodes and the request,
// result and divider stage types. No dependencies.
package fca_pkg;

  localparam int CELL_BITS   = 32;
  localparam int DBL_BITS    = 2 * CELL_BITS;
  localparam int DIV_STAGES  = DBL_BITS;

  typedef enum logic [4:0] {
    OP_ADD         = 5'd0,
    OP_SUB         = 5'd1,
    OP_DIV         = 5'd2,
    OP_MUL         = 5'd3,
    OP_TIMESDIV    = 5'd4,
    OP_DIVMOD      = 5'd5,
    OP_TIMESDIVMOD = 5'd6,
    OP_UMDIVMOD    = 5'd7,
    OP_UMDIVMOD2   = 5'd8,
    OP_MTIMES      = 5'd9,
    OP_UMTIMES     = 5'd10,
    OP_SMDIVREM    = 5'd11,
    OP_LESS        = 5'd12,
    OP_MORE        = 5'd13,
    OP_ULESS       = 5'd14,
    OP_UMORE       = 5'd15,
    OP_AND         = 5'd16,
    OP_OR          = 5'd17,
    OP_XOR         = 5'd18,
    OP_INVERT      = 5'd19,
    OP_LSHIFT      = 5'd20,
    OP_RSHIFT      = 5'd21,
    OP_EQ          = 5'd22,
    OP_DMUL        = 5'd23,
    OP_DADD        = 5'd24
  } op_t;

  typedef struct packed {
    logic [4:0]           action;
    logic [CELL_BITS-1:0] cell_a;
    logic [CELL_BITS-1:0] cell_b;
    logic [CELL_BITS-1:0] cell_c;
    logic [CELL_BITS-1:0] cell_d;
  } req_t;

  typedef struct packed {
    logic [CELL_BITS-1:0] push_first;
    logic [CELL_BITS-1:0] push_second;
    logic [CELL_BITS-1:0] push_third;
    logic [1:0]           push_count;
    logic                 zero_divide;
  } res_t;

  typedef struct packed {
    logic                 is_div;
    logic [4:0]           action;
    logic                 neg_q;
    logic                 neg_r;
    logic [CELL_BITS-1:0] md;
    logic [CELL_BITS-1:0] rem;
    logic [DBL_BITS-1:0]  q;
    res_t                 pre;
  } div_t;

endpackage

FILE: sv/forth_cell_alu.sv
// Forth cell ALU top level: input register, multiply stage, operand
// set-up stage, a restoring divider of one quotient bit per stage, and an
// output register. Depends on fca_pkg.
//
// Fully pipelined: one request enters per cycle when the result side does
// not stall, and every operation passes through the bit-per-stage divider.
// A stall on the result side holds the whole pipeline; nothing is lost.
module forth_cell_alu (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  fca_pkg::req_t req,
  output logic          res_valid,
  input  logic          res_stall,
  output fca_pkg::res_t res
);

  localparam int CB = fca_pkg::CELL_BITS;
  localparam int DB = fca_pkg::DBL_BITS;
  localparam int NS = fca_pkg::DIV_STAGES;

  logic adv;
  assign adv       = !(res_valid && res_stall);
  assign req_stall = !adv;

  // stage 0: captured request
  fca_pkg::req_t s0;
  logic          v0;

  // stage 1: products
  fca_pkg::req_t s1;
  logic          v1;
  logic [DB-1:0] pu;
  logic [CB-1:0] p1;
  logic [CB-1:0] p2;

  logic [DB-1:0] pu_next;
  logic [CB-1:0] p1_next;
  logic [CB-1:0] p2_next;
  logic [CB-1:0] mul_b;

  fca_pkg::div_t ds [0:NS];
  logic [NS:0]   vd;
  fca_pkg::div_t ds0_next;
  fca_pkg::res_t res_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0        <= 1'b0;
      v1        <= 1'b0;
      vd        <= '0;
      res_valid <= 1'b0;
    end else if (adv) begin
      v0        <= req_valid;
      v1        <= v0;
      vd        <= {vd[NS-1:0], v1};
      res_valid <= vd[NS];
    end
  end

  assign mul_b   = (s0.action == fca_pkg::OP_DMUL) ? s0.cell_c : s0.cell_b;
  assign pu_next = {{CB{1'b0}}, s0.cell_a} * {{CB{1'b0}}, mul_b};
  assign p1_next = s0.cell_a * s0.cell_d;
  assign p2_next = s0.cell_b * s0.cell_c;

  always_ff @(posedge clk) begin
    if (adv) begin
      s0    <= req;
      s1    <= s0;
      pu    <= pu_next;
      p1    <= p1_next;
      p2    <= p2_next;
      ds[0] <= ds0_next;
      res   <= res_next;
    end
  end

  // stage 2: operand set-up and non-division results
  logic [DB-1:0] sprod;
  logic [DB-1:0] dmul;
  logic [DB-1:0] dadd;
  logic [DB-1:0] num;
  logic [CB-1:0] dvs;
  logic          sgn;
  logic          n_neg;
  logic          d_neg;
  logic          big_shift;
  logic          lt_s;
  logic          gt_s;

  assign sprod = pu - {(s1.cell_a[CB-1] ? s1.cell_b : {CB{1'b0}}), {CB{1'b0}}}
                    - {(s1.cell_b[CB-1] ? s1.cell_a : {CB{1'b0}}), {CB{1'b0}}};
  assign dmul  = pu + {p1 + p2, {CB{1'b0}}};
  assign dadd  = {s1.cell_b, s1.cell_a} + {s1.cell_d, s1.cell_c};
  assign big_shift = |s1.cell_b[CB-1:$clog2(CB)];
  assign lt_s  = $signed(s1.cell_a) < $signed(s1.cell_b);
  assign gt_s  = $signed(s1.cell_a) > $signed(s1.cell_b);

  always_comb begin
    ds0_next     = '0;
    ds0_next.action = s1.action;
    num          = '0;
    dvs          = s1.cell_c;
    sgn          = 1'b1;
    ds0_next.pre.push_count = 2'd1;
    case (s1.action)
      fca_pkg::OP_DIV, fca_pkg::OP_DIVMOD: begin
        num = {{CB{s1.cell_a[CB-1]}}, s1.cell_a};
        dvs = s1.cell_b;
        ds0_next.is_div = 1'b1;
      end
      fca_pkg::OP_TIMESDIV, fca_pkg::OP_TIMESDIVMOD: begin
        num = sprod;
        ds0_next.is_div = 1'b1;
      end
      fca_pkg::OP_UMDIVMOD, fca_pkg::OP_UMDIVMOD2: begin
        num = {s1.cell_b, s1.cell_a};
        sgn = 1'b0;
        ds0_next.is_div = 1'b1;
      end
      fca_pkg::OP_SMDIVREM: begin
        num = {s1.cell_b, s1.cell_a};
        ds0_next.is_div = 1'b1;
      end
      fca_pkg::OP_ADD:    ds0_next.pre.push_first = s1.cell_a + s1.cell_b;
      fca_pkg::OP_SUB:    ds0_next.pre.push_first = s1.cell_a - s1.cell_b;
      fca_pkg::OP_MUL:    ds0_next.pre.push_first = pu[CB-1:0];
      fca_pkg::OP_MTIMES: begin
        ds0_next.pre.push_first  = sprod[CB-1:0];
        ds0_next.pre.push_second = sprod[DB-1:CB];
      end
      fca_pkg::OP_UMTIMES: begin
        ds0_next.pre.push_first  = pu[CB-1:0];
        ds0_next.pre.push_second = pu[DB-1:CB];
      end
      fca_pkg::OP_LESS:   ds0_next.pre.push_first = {CB{lt_s}};
      fca_pkg::OP_MORE:   ds0_next.pre.push_first = {CB{gt_s}};
      fca_pkg::OP_ULESS:  ds0_next.pre.push_first = {CB{s1.cell_a < s1.cell_b}};
      fca_pkg::OP_UMORE:  ds0_next.pre.push_first = {CB{s1.cell_a > s1.cell_b}};
      fca_pkg::OP_AND:    ds0_next.pre.push_first = s1.cell_a & s1.cell_b;
      fca_pkg::OP_OR:     ds0_next.pre.push_first = s1.cell_a | s1.cell_b;
      fca_pkg::OP_XOR:    ds0_next.pre.push_first = s1.cell_a ^ s1.cell_b;
      fca_pkg::OP_INVERT: ds0_next.pre.push_first = ~s1.cell_a;
      fca_pkg::OP_LSHIFT: ds0_next.pre.push_first =
        big_shift ? '0 : s1.cell_a << s1.cell_b[$clog2(CB)-1:0];
      fca_pkg::OP_RSHIFT: ds0_next.pre.push_first =
        big_shift ? '0 : s1.cell_a >> s1.cell_b[$clog2(CB)-1:0];
      fca_pkg::OP_EQ:     ds0_next.pre.push_first = {CB{s1.cell_a == s1.cell_b}};
      fca_pkg::OP_DMUL: begin
        ds0_next.pre.push_first  = dmul[CB-1:0];
        ds0_next.pre.push_second = dmul[DB-1:CB];
      end
      fca_pkg::OP_DADD: begin
        ds0_next.pre.push_first  = dadd[CB-1:0];
        ds0_next.pre.push_second = dadd[DB-1:CB];
      end
      default: ds0_next.pre.push_count = 2'd0;
    endcase
    case (s1.action)
      fca_pkg::OP_DIV, fca_pkg::OP_TIMESDIV: ds0_next.pre.push_count = 2'd1;
      fca_pkg::OP_UMDIVMOD2:                 ds0_next.pre.push_count = 2'd3;
      fca_pkg::OP_DIVMOD, fca_pkg::OP_TIMESDIVMOD, fca_pkg::OP_UMDIVMOD,
      fca_pkg::OP_SMDIVREM, fca_pkg::OP_MTIMES, fca_pkg::OP_UMTIMES,
      fca_pkg::OP_DMUL, fca_pkg::OP_DADD:    ds0_next.pre.push_count = 2'd2;
      default: ;
    endcase
    n_neg = sgn && num[DB-1];
    d_neg = sgn && dvs[CB-1];
    ds0_next.neg_q = n_neg ^ d_neg;
    ds0_next.neg_r = n_neg;
    ds0_next.q     = n_neg ? -num : num;
    ds0_next.md    = d_neg ? -dvs : dvs;
    ds0_next.pre.zero_divide = ds0_next.is_div && (dvs == '0);
  end

  // restoring divider, one quotient bit per stage
  for (genvar k = 0; k < NS; k++) begin : g_div
    logic [CB:0]   t;
    logic [CB:0]   diff;
    fca_pkg::div_t stage_next;
    assign t    = {ds[k].rem, ds[k].q[DB-1]};
    assign diff = t - {1'b0, ds[k].md};
    always_comb begin
      stage_next     = ds[k];
      stage_next.rem = diff[CB] ? t[CB-1:0] : diff[CB-1:0];
      stage_next.q   = {ds[k].q[DB-2:0], ~diff[CB]};
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        ds[k+1] <= stage_next;
      end
    end
  end

  // final sign fix and result selection
  logic [DB-1:0] qq;
  logic [CB-1:0] rr;
  assign qq = ds[NS].neg_q ? -ds[NS].q : ds[NS].q;
  assign rr = ds[NS].neg_r ? -ds[NS].rem : ds[NS].rem;

  always_comb begin
    res_next = ds[NS].pre;
    if (ds[NS].is_div) begin
      case (ds[NS].action)
        fca_pkg::OP_DIV, fca_pkg::OP_TIMESDIV: res_next.push_first = qq[CB-1:0];
        fca_pkg::OP_UMDIVMOD2: begin
          res_next.push_first  = rr;
          res_next.push_second = qq[CB-1:0];
          res_next.push_third  = qq[DB-1:CB];
        end
        default: begin
          res_next.push_first  = rr;
          res_next.push_second = qq[CB-1:0];
        end
      endcase
      if (ds[NS].pre.zero_divide) begin
        res_next.push_first  = '1;
        res_next.push_second = (ds[NS].pre.push_count >= 2'd2) ? '1 : '0;
        res_next.push_third  = (ds[NS].pre.push_count == 2'd3) ? '1 : '0;
      end
    end
  end

endmodule

FILE: verif/forth_cell_alu_tb.sv
// Self-checking bench for forth_cell_alu: random and directed requests, each
// result checked against an in-bench arithmetic predictor. Depends on fca_pkg.
`timescale 1ns / 100ps

module forth_cell_alu_tb;

  localparam int LATENCY = 2 * fca_pkg::CELL_BITS + 4;
  localparam int N_RAND = 700;
  localparam int LIMIT = 400000;
  localparam logic [31:0] ONES = 32'hffffffff;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  fca_pkg::req_t req = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  fca_pkg::res_t res;

  fca_pkg::req_t pending_q[$];
  fca_pkg::res_t expected_q[$];
  int errors = 0;
  int cycles = 0;
  bit quiet = 1'b0;
  bit holdoff = 1'b0;
  int src_gap = 0;
  int snk_gap = 0;

  forth_cell_alu u_top (
    .clk(clk), .rst(rst), .req_valid(req_valid), .req_stall(req_stall),
    .req(req), .res_valid(res_valid), .res_stall(res_stall), .res(res)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic logic [63:0] sx(logic [31:0] v);
    return {{32{v[31]}}, v};
  endfunction

  // truncating signed divide on 64-bit values
  function automatic void sdiv(logic [63:0] n, logic [63:0] d,
                               output logic [63:0] q, output logic [63:0] r);
    logic [63:0] mn, md;
    mn = n[63] ? -n : n;
    md = d[63] ? -d : d;
    q = mn / md;
    r = mn % md;
    if (n[63] != d[63]) q = -q;
    if (n[63]) r = -r;
  endfunction

  function automatic fca_pkg::res_t alu_result(fca_pkg::req_t rq);
    fca_pkg::res_t o;
    logic [31:0] a, b, c, d;
    logic [63:0] q, m, t, x, y;
    o = '0;
    a = rq.cell_a; b = rq.cell_b; c = rq.cell_c; d = rq.cell_d;
    o.push_count = 2'd1;
    case (rq.action)
      fca_pkg::OP_ADD: o.push_first = a + b;
      fca_pkg::OP_SUB: o.push_first = a - b;
      fca_pkg::OP_MUL: o.push_first = a * b;
      fca_pkg::OP_DIV, fca_pkg::OP_DIVMOD: begin
        if (rq.action == fca_pkg::OP_DIVMOD) o.push_count = 2'd2;
        if (b == 0) begin
          o.zero_divide = 1'b1; o.push_first = ONES;
          if (rq.action == fca_pkg::OP_DIVMOD) o.push_second = ONES;
        end else begin
          sdiv(sx(a), sx(b), q, m);
          if (rq.action == fca_pkg::OP_DIV) o.push_first = q[31:0];
          else begin o.push_first = m[31:0]; o.push_second = q[31:0]; end
        end
      end
      fca_pkg::OP_TIMESDIV, fca_pkg::OP_TIMESDIVMOD: begin
        if (rq.action == fca_pkg::OP_TIMESDIVMOD) o.push_count = 2'd2;
        if (c == 0) begin
          o.zero_divide = 1'b1; o.push_first = ONES;
          if (rq.action == fca_pkg::OP_TIMESDIVMOD) o.push_second = ONES;
        end else begin
          t = sx(a) * sx(b);
          sdiv(t, sx(c), q, m);
          if (rq.action == fca_pkg::OP_TIMESDIV) o.push_first = q[31:0];
          else begin o.push_first = m[31:0]; o.push_second = q[31:0]; end
        end
      end
      fca_pkg::OP_UMDIVMOD, fca_pkg::OP_UMDIVMOD2: begin
        o.push_count = (rq.action == fca_pkg::OP_UMDIVMOD) ? 2'd2 : 2'd3;
        if (c == 0) begin
          o.zero_divide = 1'b1; o.push_first = ONES; o.push_second = ONES;
          if (rq.action == fca_pkg::OP_UMDIVMOD2) o.push_third = ONES;
        end else begin
          t = {b, a};
          q = t / c;
          m = t % c;
          o.push_first = m[31:0]; o.push_second = q[31:0];
          if (rq.action == fca_pkg::OP_UMDIVMOD2) o.push_third = q[63:32];
        end
      end
      fca_pkg::OP_MTIMES: begin
        o.push_count = 2'd2; t = sx(a) * sx(b);
        o.push_first = t[31:0]; o.push_second = t[63:32];
      end
      fca_pkg::OP_UMTIMES: begin
        o.push_count = 2'd2; t = {32'd0, a} * {32'd0, b};
        o.push_first = t[31:0]; o.push_second = t[63:32];
      end
      fca_pkg::OP_SMDIVREM: begin
        o.push_count = 2'd2;
        if (c == 0) begin
          o.zero_divide = 1'b1; o.push_first = ONES; o.push_second = ONES;
        end else begin
          sdiv({b, a}, sx(c), q, m);
          o.push_first = m[31:0]; o.push_second = q[31:0];
        end
      end
      fca_pkg::OP_LESS: o.push_first = ($signed(a) < $signed(b)) ? ONES : '0;
      fca_pkg::OP_MORE: o.push_first = ($signed(a) > $signed(b)) ? ONES : '0;
      fca_pkg::OP_ULESS: o.push_first = (a < b) ? ONES : '0;
      fca_pkg::OP_UMORE: o.push_first = (a > b) ? ONES : '0;
      fca_pkg::OP_AND: o.push_first = a & b;
      fca_pkg::OP_OR: o.push_first = a | b;
      fca_pkg::OP_XOR: o.push_first = a ^ b;
      fca_pkg::OP_INVERT: o.push_first = ~a;
      fca_pkg::OP_LSHIFT: o.push_first = (b >= 32) ? '0 : a << b[4:0];
      fca_pkg::OP_RSHIFT: o.push_first = (b >= 32) ? '0 : a >> b[4:0];
      fca_pkg::OP_EQ: o.push_first = (a == b) ? ONES : '0;
      fca_pkg::OP_DMUL, fca_pkg::OP_DADD: begin
        o.push_count = 2'd2;
        x = {b, a}; y = {d, c};
        t = (rq.action == fca_pkg::OP_DMUL) ? x * y : x + y;
        o.push_first = t[31:0]; o.push_second = t[63:32];
      end
      default: o.push_count = 2'd0;
    endcase
    return o;
  endfunction

  function automatic logic [31:0] rand_cell();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return ONES;
      2: return 32'h80000000;
      3: return 32'h7fffffff;
      4: return $urandom_range(0, 40);
      5: return -$urandom_range(1, 5);
      default: return $urandom;
    endcase
  endfunction

  task automatic add_req(logic [4:0] op, logic [31:0] a, logic [31:0] b,
                         logic [31:0] c, logic [31:0] d);
    fca_pkg::req_t r;
    r.action = op; r.cell_a = a; r.cell_b = b; r.cell_c = c; r.cell_d = d;
    pending_q.push_back(r);
  endtask

  initial begin
    fca_pkg::req_t r;
    for (int op = 0; op < 25; op++)
      add_req(op[4:0], ONES, 32'h80000000, 32'h7fffffff, ONES);
    add_req(fca_pkg::OP_DIV, 32'h80000000, ONES, 0, 0);
    add_req(fca_pkg::OP_DIVMOD, 5, 0, 0, 0);
    add_req(fca_pkg::OP_UMDIVMOD2, ONES, ONES, 1, 0);
    add_req(fca_pkg::OP_SMDIVREM, 7, 0, 0, 0);
    add_req(fca_pkg::OP_LSHIFT, ONES, 32, 0, 0);
    add_req(fca_pkg::OP_RSHIFT, ONES, 31, 0, 0);
    add_req(5'd31, ONES, ONES, ONES, ONES);
    for (int i = 0; i < N_RAND; i++) begin
      r.action = ($urandom_range(0, 15) == 0) ? 5'($urandom_range(25, 31))
                                               : 5'($urandom_range(0, 24));
      r.cell_a = rand_cell(); r.cell_b = rand_cell();
      r.cell_c = rand_cell(); r.cell_d = rand_cell();
      if ((r.action == fca_pkg::OP_LSHIFT || r.action == fca_pkg::OP_RSHIFT)
          && $urandom_range(0, 1))
        r.cell_b = $urandom_range(0, 40);
      pending_q.push_back(r);
    end
  end

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!req_valid || !req_stall) begin
      if (src_gap > 0) begin
        src_gap <= src_gap - 1;
        req_valid <= 1'b0;
      end else if (pending_q.size() > 0) begin
        if (!quiet && $urandom_range(0, 9) == 0) begin
          src_gap <= $urandom_range(0, 6);
          req_valid <= 1'b0;
        end else begin
          req <= pending_q[0];
          expected_q.push_back(alu_result(pending_q[0]));
          void'(pending_q.pop_front());
          req_valid <= 1'b1;
        end
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // long receiver hold-off once, mid run
  initial begin
    wait (!rst);
    repeat (300) @(posedge clk);
    holdoff = 1'b1;
    repeat (200) @(posedge clk);
    holdoff = 1'b0;
  end

  // result monitor
  always @(posedge clk) begin
    fca_pkg::res_t e;
    if (!rst) begin
      if (res_valid && !res_stall) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result %h", $time, res);
          errors++;
        end else begin
          e = expected_q.pop_front();
          if (res !== e) begin
            $display("%0t: mismatch expected %h actual %h", $time, e, res);
            errors++;
          end
        end
      end
      if (holdoff) res_stall <= 1'b1;
      else if (snk_gap > 0) begin
        snk_gap <= snk_gap - 1;
        res_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        snk_gap <= $urandom_range(0, 6);
        res_stall <= 1'b1;
      end else res_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    wait (pending_q.size() < 150);
    quiet = 1'b1;
    wait (pending_q.size() == 0);
    @(posedge clk);
    while (expected_q.size() > 0 || req_valid) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
    if (errors == 0 && expected_q.size() == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
